>>> hw/rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
package bba_pkg;

    localparam int ORDER_W = 5;
    localparam int SIZE_W  = 21;
    localparam int OFFS_W  = 20;
    localparam int STAT_W  = 2;

    localparam logic [ORDER_W-1:0] POOL_RESET      = 5'd16;
    localparam logic [ORDER_W-1:0] MIN_RESET       = 5'd4;
    localparam logic [ORDER_W-1:0] POOL_FLOOR      = 5'd3;
    localparam logic [ORDER_W-1:0] MIN_BLOCK_ORDER = 5'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic CFG_POOL = 1'b0;
    localparam logic CFG_MIN  = 1'b1;

    typedef enum logic [1:0] {
        MARK_UNUSED = 2'd0,
        MARK_USED   = 2'd1,
        MARK_SPLIT  = 2'd2,
        MARK_FULL   = 2'd3
    } t_mark;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_BADFREE  = 2'd2
    } t_status;

    typedef struct packed {
        logic [ORDER_W-1:0] pool;
        logic [ORDER_W-1:0] minb;
    } t_geom;

endpackage

>>> hw/rtl/buddy_block_allocator.sv
// Buddy block allocator top level: request sequencer over the node mark memory.
//
//  channel  | direction | handshake               | payload
//  in       | input     | i_in_valid / o_in_stall | i_req_type, i_req_size, i_free_offset
//  out      | output    | o_out_valid/i_out_stall | o_status, o_block_offset, o_block_order
//  cfg      | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// One item at a time; each node is read, then evaluated, via the one mark memory
// read port. Backing off climbs one level per advance step. A merge step reads both
// children, then checks; each full-to-split fixup after a free reads, then checks.
// Reset and every config write start a clearing pass over all 2^TREE_LEVELS nodes.
// Items are taken only when the sequencer is idle; a result waits in the output
// register while the next item is accepted.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS    = 13,
    parameter int MAX_POOL_ORDER = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [ORDER_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic [SIZE_W-1:0]   i_req_size,
    input  logic [OFFS_W-1:0]   i_free_offset,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STAT_W-1:0]   o_status,
    output logic [OFFS_W-1:0]   o_block_offset,
    output logic [ORDER_W-1:0]  o_block_order
);

    localparam int AW    = TREE_LEVELS;
    localparam int NODES = 1 << TREE_LEVELS;
    localparam logic [AW-1:0] ROOT = AW'(1);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_A_RD  = 13'b0000000000100,
        S_A_EV  = 13'b0000000001000,
        S_A_ADV = 13'b0000000010000,
        S_U_RL  = 13'b0000000100000,
        S_U_RR  = 13'b0000001000000,
        S_U_CK  = 13'b0000010000000,
        S_F_RD  = 13'b0000100000000,
        S_F_EV  = 13'b0001000000000,
        S_G_RD  = 13'b0010000000000,
        S_G_CK  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_geom geom;

    bba_cfg #(
        .TREE_LEVELS    (TREE_LEVELS),
        .MAX_POOL_ORDER (MAX_POOL_ORDER)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    logic [1:0] r_mem [0:NODES-1];
    logic [1:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_mark         mem_wd;
    logic [AW-1:0] mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    t_state             r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_up, n_up;
    logic [ORDER_W-1:0] r_depth, n_depth;
    logic [ORDER_W-1:0] r_k, n_k;
    logic [OFFS_W-1:0]  r_off, n_off;
    logic [OFFS_W-1:0]  r_cur, n_cur;
    logic               r_free, n_free;
    t_mark              r_left, n_left;
    t_status            r_res_st, n_res_st;
    logic [OFFS_W-1:0]  r_res_offs, n_res_offs;
    logic [ORDER_W-1:0] r_res_ord, n_res_ord;
    logic               r_out_valid, n_out_valid;
    t_status            r_o_st, n_o_st;
    logic [OFFS_W-1:0]  r_o_offs, n_o_offs;
    logic [ORDER_W-1:0] r_o_ord, n_o_ord;

    logic [SIZE_W-1:0]  pool_bytes;
    logic [SIZE_W-1:0]  size_m1;
    logic [ORDER_W-1:0] clog;
    logic [ORDER_W-1:0] o_cur;
    t_mark              v;
    logic               both;
    logic [AW-1:0]      up_par;
    logic [OFFS_W-1:0]  half;
    logic [SIZE_W-1:0]  mid;
    logic [31:0]        rel;

    always_comb begin
        pool_bytes = SIZE_W'(1) << geom.pool;
        size_m1    = i_req_size - SIZE_W'(1);
        clog       = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (size_m1[i]) begin
                clog = ORDER_W'(i + 1);
            end
        end
        if (i_req_size <= SIZE_W'(1)) begin
            clog = '0;
        end
        o_cur  = geom.pool - r_depth;
        v      = t_mark'(r_rd_data);
        up_par = r_up >> 1;
        half   = OFFS_W'(1) << (o_cur - 5'd1);
        mid    = {1'b0, r_cur} + {1'b0, half};
        rel    = (32'(r_idx) - (32'd1 << r_depth)) << o_cur;
        if (r_free) begin
            both = (r_left == MARK_UNUSED) && (v == MARK_UNUSED);
        end else begin
            both = (r_left == MARK_USED || r_left == MARK_FULL) &&
                   (v == MARK_USED || v == MARK_FULL);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_up        = r_up;
        n_depth     = r_depth;
        n_k         = r_k;
        n_off       = r_off;
        n_cur       = r_cur;
        n_free      = r_free;
        n_left      = r_left;
        n_res_st    = r_res_st;
        n_res_offs  = r_res_offs;
        n_res_ord   = r_res_ord;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_st      = r_o_st;
        n_o_offs    = r_o_offs;
        n_o_ord     = r_o_ord;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = MARK_UNUSED;
        mem_ra      = r_idx;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + AW'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_idx      = ROOT;
                n_depth    = '0;
                n_cur      = '0;
                n_off      = i_free_offset;
                n_free     = i_req_type;
                n_k        = (clog < geom.minb) ? geom.minb : clog;
                n_res_offs = '0;
                n_res_ord  = '0;
                if (i_in_valid) begin
                    if (i_req_type == REQ_ALLOC) begin
                        if (i_req_size > pool_bytes) begin
                            n_res_st = ST_NOSPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else begin
                        if ({1'b0, i_free_offset} >= pool_bytes) begin
                            n_res_st = ST_BADFREE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_EV;
            end
            S_A_EV: begin
                if (v == MARK_UNUSED && o_cur == r_k) begin
                    mem_we     = 1'b1;
                    mem_wd     = MARK_USED;
                    n_up       = r_idx;
                    n_res_st   = ST_OK;
                    n_res_offs = rel[OFFS_W-1:0];
                    n_res_ord  = o_cur;
                    n_state    = (r_idx == ROOT) ? S_DONE : S_U_RL;
                end else if (v == MARK_UNUSED && o_cur > r_k) begin
                    mem_we  = 1'b1;
                    mem_wd  = MARK_SPLIT;
                    n_idx   = {r_idx[AW-2:0], 1'b0};
                    n_depth = r_depth + 5'd1;
                    n_state = S_A_RD;
                end else if (v == MARK_SPLIT && o_cur > r_k) begin
                    n_idx   = {r_idx[AW-2:0], 1'b0};
                    n_depth = r_depth + 5'd1;
                    n_state = S_A_RD;
                end else begin
                    n_state = S_A_ADV;
                end
            end
            S_A_ADV: begin
                if (r_idx == ROOT) begin
                    n_res_st = ST_NOSPACE;
                    n_state  = S_DONE;
                end else if (r_idx[0]) begin
                    n_idx   = r_idx >> 1;
                    n_depth = r_depth - 5'd1;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_A_RD;
                end
            end
            S_U_RL: begin
                mem_ra  = {r_up[AW-1:1], 1'b0};
                n_state = S_U_RR;
            end
            S_U_RR: begin
                mem_ra  = {r_up[AW-1:1], 1'b1};
                n_left  = v;
                n_state = S_U_CK;
            end
            S_U_CK: begin
                if (both) begin
                    mem_we = 1'b1;
                    mem_wa = up_par;
                    mem_wd = r_free ? MARK_UNUSED : MARK_FULL;
                    n_up   = up_par;
                    if (up_par != ROOT) begin
                        n_state = S_U_RL;
                    end else begin
                        n_up    = r_idx;
                        n_state = r_free ? S_G_RD : S_DONE;
                    end
                end else begin
                    n_up    = r_idx;
                    n_state = r_free ? S_G_RD : S_DONE;
                end
            end
            S_F_RD: begin
                n_state = S_F_EV;
            end
            S_F_EV: begin
                if (v == MARK_USED) begin
                    if (r_cur != r_off) begin
                        n_res_st = ST_BADFREE;
                        n_state  = S_DONE;
                    end else begin
                        mem_we     = 1'b1;
                        mem_wd     = MARK_UNUSED;
                        n_up       = r_idx;
                        n_res_st   = ST_OK;
                        n_res_offs = r_cur;
                        n_res_ord  = o_cur;
                        n_state    = (r_idx == ROOT) ? S_DONE : S_U_RL;
                    end
                end else if (v == MARK_UNUSED || r_depth >= (geom.pool - geom.minb)) begin
                    n_res_st = ST_BADFREE;
                    n_state  = S_DONE;
                end else begin
                    n_depth = r_depth + 5'd1;
                    if ({1'b0, r_off} >= mid) begin
                        n_idx = {r_idx[AW-2:0], 1'b1};
                        n_cur = mid[OFFS_W-1:0];
                    end else begin
                        n_idx = {r_idx[AW-2:0], 1'b0};
                    end
                    n_state = S_F_RD;
                end
            end
            S_G_RD: begin
                mem_ra = up_par;
                if (r_up != ROOT) begin
                    n_up    = up_par;
                    n_state = S_G_CK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_G_CK: begin
                if (v == MARK_FULL) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_up;
                    mem_wd  = MARK_SPLIT;
                    n_state = S_G_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_st      = r_res_st;
                    n_o_offs    = r_res_offs;
                    n_o_ord     = r_res_ord;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase

        if (i_cfg_we) begin
            n_state = S_CLEAR;
            n_clr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_up       <= n_up;
        r_depth    <= n_depth;
        r_k        <= n_k;
        r_off      <= n_off;
        r_cur      <= n_cur;
        r_free     <= n_free;
        r_left     <= n_left;
        r_res_st   <= n_res_st;
        r_res_offs <= n_res_offs;
        r_res_ord  <= n_res_ord;
        r_o_st     <= n_o_st;
        r_o_offs   <= n_o_offs;
        r_o_ord    <= n_o_ord;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_st;
    assign o_block_offset = r_o_offs;
    assign o_block_order  = r_o_ord;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("mark memory written while idle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_block_offset == '0 && o_block_order == '0))
        else $error("failed item carries nonzero fields");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == S_CLEAR))
        else $error("config write did not start clearing pass");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_EV || r_state == S_F_EV) |-> (r_depth <= geom.pool - geom.minb))
        else $error("descent below minimum block level");

endmodule

>>> hw/rtl/bba_cfg.sv
// Configuration registers and effective pool and minimum block orders.
module bba_cfg
    import bba_pkg::*;
#(
    parameter int TREE_LEVELS    = 13,
    parameter int MAX_POOL_ORDER = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [ORDER_W-1:0] i_cfg_data,
    output t_geom              o_geom
);

    localparam logic [ORDER_W-1:0] MAXP  = ORDER_W'(MAX_POOL_ORDER);
    localparam logic [ORDER_W-1:0] SPAN  = ORDER_W'(TREE_LEVELS - 1);

    logic [ORDER_W-1:0] r_pool;
    logic [ORDER_W-1:0] r_min;
    logic [ORDER_W-1:0] p;
    logic [ORDER_W-1:0] m1;
    logic [ORDER_W-1:0] m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= POOL_RESET;
            r_min  <= MIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_POOL) begin
                r_pool <= i_cfg_data;
            end else begin
                r_min <= i_cfg_data;
            end
        end
    end

    always_comb begin
        p  = (r_pool < POOL_FLOOR) ? POOL_FLOOR : ((r_pool > MAXP) ? MAXP : r_pool);
        m1 = (r_min < MIN_BLOCK_ORDER) ? MIN_BLOCK_ORDER : r_min;
        m2 = (m1 >= p) ? p - 5'd1 : m1;
        o_geom.pool = p;
        if ({1'b0, p} > ({1'b0, m2} + {1'b0, SPAN})) begin
            o_geom.minb = p - SPAN;
        end else begin
            o_geom.minb = m2;
        end
    end

endmodule
